FILE: rtl/alt_pkg.sv
// Shared types and constants for the assembly line tokenizer.
// Holds the result record, result kinds, status codes and character classes.
`timescale 1ns / 1ps

package alt_pkg;

  localparam int CFG_AW = 3;

  localparam logic [0:0] REG_EXPECTED_OPS = 1'b0;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_OPERAND = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_EMPTY      = 4'd1;
  localparam logic [3:0] ST_BAD_START  = 4'd2;
  localparam logic [3:0] ST_OPEN_STR   = 4'd3;
  localparam logic [3:0] ST_BAD_CHAR   = 4'd4;
  localparam logic [3:0] ST_NO_COMMA   = 4'd5;
  localparam logic [3:0] ST_EARLY_END  = 4'd6;
  localparam logic [3:0] ST_TRAILING   = 4'd7;
  localparam logic [3:0] ST_COUNT      = 4'd8;
  localparam logic [3:0] ST_TOO_LONG   = 4'd9;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] operand_index;
    logic [9:0] position;
    logic [3:0] status;
    logic       line_end;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_body(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_lead(input logic [7:0] c);
    return is_body(c) || (c == CH_DOLLAR) || (c == CH_QUOTE);
  endfunction

endpackage

FILE: rtl/alt_in_stage.sv
// Input register stage: holds one character request until the core takes it.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module alt_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       take,
  output logic       q_valid,
  output logic [7:0] q_ch
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] ch_r;
  logic       load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r <= in_ch;
    end
  end

  assign q_valid = valid_r;
  assign q_ch    = ch_r;

endmodule

FILE: rtl/alt_core.sv
// Tokenizer state machine: one transition per character, with the line state.
// Depends on alt_pkg for the result record, codes and character classes.
`timescale 1ns / 1ps

module alt_core #(
  parameter int MAX_LINE     = 1024,
  parameter int MAX_OPERANDS = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      ch,
  input  logic [4:0]      exp_ops,
  output logic            res_valid,
  output alt_pkg::result_t res
);

  localparam int PW  = $clog2(MAX_LINE);
  localparam int OPW = $clog2(MAX_OPERANDS + 1);
  localparam int CW  = (OPW > 5) ? OPW : 5;
  localparam logic [PW-1:0] LAST_POS = PW'(MAX_LINE - 1);
  localparam logic [CW-1:0] MAX_OPS  = CW'(MAX_OPERANDS);

  localparam logic [3:0] PH_LEAD       = 4'd0;
  localparam logic [3:0] PH_NAME       = 4'd1;
  localparam logic [3:0] PH_NAME_STR   = 4'd2;
  localparam logic [3:0] PH_AFTER_NAME = 4'd3;
  localparam logic [3:0] PH_OPER       = 4'd4;
  localparam logic [3:0] PH_OPER_STR   = 4'd5;
  localparam logic [3:0] PH_GAP        = 4'd6;
  localparam logic [3:0] PH_GAP_COMMA  = 4'd7;
  localparam logic [3:0] PH_TRAIL      = 4'd8;
  localparam logic [3:0] PH_DRAIN      = 4'd9;

  logic [3:0]     phase_r, phase_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [OPW-1:0] seen_r, seen_nxt;
  logic           comma_r, comma_nxt;
  logic [3:0]     err_r, err_nxt;

  logic [31:0]    pos_w;
  logic [31:0]    seen_w;
  logic [CW-1:0]  seen_c;
  logic [CW-1:0]  exp_c;
  logic           at_limit;
  logic           reached;
  logic           op_full;
  logic           is_quote;
  logic [3:0]     fin_status;
  logic           fail_en;
  logic [3:0]     fail_code;
  logic           start_op;

  assign pos_w    = 32'(pos_r);
  assign seen_w   = 32'(seen_r);
  assign seen_c   = CW'(seen_r);
  assign exp_c    = CW'(exp_ops);
  assign at_limit = (pos_r >= LAST_POS);
  assign reached  = (seen_c >= exp_c);
  assign op_full  = reached || (seen_c >= MAX_OPS);
  assign is_quote = (ch == alt_pkg::CH_QUOTE);

  always_comb begin
    if (err_r != alt_pkg::ST_OK) begin
      fin_status = err_r;
    end else begin
      unique case (phase_r)
        PH_LEAD:                   fin_status = alt_pkg::ST_EMPTY;
        PH_NAME_STR, PH_OPER_STR:  fin_status = alt_pkg::ST_OPEN_STR;
        PH_GAP, PH_GAP_COMMA:      fin_status = alt_pkg::ST_EARLY_END;
        default: fin_status = (seen_c < exp_c) ? alt_pkg::ST_EARLY_END : alt_pkg::ST_OK;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    comma_nxt = comma_r;
    err_nxt   = err_r;
    fail_en   = 1'b0;
    fail_code = alt_pkg::ST_OK;
    start_op  = 1'b0;
    res_valid = 1'b0;
    res.kind          = alt_pkg::KIND_NAME;
    res.operand_index = seen_w[4:0];
    res.position      = pos_w[9:0];
    res.status        = alt_pkg::ST_OK;
    res.line_end      = 1'b0;

    if (step) begin
      if (ch == alt_pkg::CH_NUL) begin
        res_valid    = 1'b1;
        res.kind     = alt_pkg::KIND_FINISH;
        res.status   = fin_status;
        res.line_end = 1'b1;
        phase_nxt    = PH_LEAD;
        pos_nxt      = '0;
        seen_nxt     = '0;
        comma_nxt    = 1'b0;
        err_nxt      = alt_pkg::ST_OK;
      end else begin
        if (err_r == alt_pkg::ST_OK) begin
          if (at_limit) begin
            fail_en   = 1'b1;
            fail_code = alt_pkg::ST_TOO_LONG;
          end else begin
            unique case (phase_r)
              PH_LEAD: begin
                if (alt_pkg::is_blank(ch)) begin
                  phase_nxt = phase_r;
                end else if (!alt_pkg::is_lead(ch)) begin
                  fail_en   = 1'b1;
                  fail_code = alt_pkg::ST_BAD_START;
                end else begin
                  res_valid         = 1'b1;
                  res.operand_index = '0;
                  phase_nxt         = is_quote ? PH_NAME_STR : PH_NAME;
                end
              end
              PH_NAME: begin
                if (alt_pkg::is_body(ch)) begin
                  phase_nxt = phase_r;
                end else if (alt_pkg::is_blank(ch)) begin
                  phase_nxt = PH_AFTER_NAME;
                end else begin
                  fail_en   = 1'b1;
                  fail_code = alt_pkg::ST_BAD_CHAR;
                end
              end
              PH_NAME_STR: begin
                if (is_quote) begin
                  phase_nxt = PH_NAME;
                end
              end
              PH_AFTER_NAME, PH_GAP_COMMA: begin
                if (alt_pkg::is_blank(ch)) begin
                  phase_nxt = phase_r;
                end else if (!alt_pkg::is_lead(ch)) begin
                  fail_en   = 1'b1;
                  fail_code = alt_pkg::ST_BAD_START;
                end else begin
                  start_op = 1'b1;
                end
              end
              PH_OPER: begin
                if (alt_pkg::is_body(ch)) begin
                  phase_nxt = phase_r;
                end else if (alt_pkg::is_blank(ch) || (ch == alt_pkg::CH_COMMA)) begin
                  if (reached) begin
                    phase_nxt = PH_TRAIL;
                  end else if (ch == alt_pkg::CH_COMMA) begin
                    phase_nxt = PH_GAP_COMMA;
                  end else begin
                    phase_nxt = PH_GAP;
                    comma_nxt = (seen_r == OPW'(1));
                  end
                end else begin
                  fail_en   = 1'b1;
                  fail_code = alt_pkg::ST_BAD_CHAR;
                end
              end
              PH_OPER_STR: begin
                if (is_quote) begin
                  phase_nxt = PH_OPER;
                end
              end
              PH_GAP: begin
                if (alt_pkg::is_blank(ch)) begin
                  phase_nxt = phase_r;
                end else if (ch == alt_pkg::CH_COMMA) begin
                  phase_nxt = PH_GAP_COMMA;
                end else if (!alt_pkg::is_lead(ch)) begin
                  fail_en   = 1'b1;
                  fail_code = alt_pkg::ST_BAD_CHAR;
                end else if (!comma_r) begin
                  fail_en   = 1'b1;
                  fail_code = alt_pkg::ST_NO_COMMA;
                end else begin
                  start_op = 1'b1;
                end
              end
              PH_TRAIL: begin
                if (!alt_pkg::is_blank(ch)) begin
                  fail_en   = 1'b1;
                  fail_code = alt_pkg::ST_TRAILING;
                end
              end
              default: begin
                phase_nxt = PH_DRAIN;
              end
            endcase
          end

          if (start_op) begin
            if (op_full) begin
              fail_en   = 1'b1;
              fail_code = alt_pkg::ST_COUNT;
            end else begin
              res_valid = 1'b1;
              res.kind  = alt_pkg::KIND_OPERAND;
              seen_nxt  = seen_r + 1'b1;
              phase_nxt = is_quote ? PH_OPER_STR : PH_OPER;
            end
          end

          if (fail_en) begin
            err_nxt   = fail_code;
            phase_nxt = PH_DRAIN;
          end
        end

        if (!at_limit) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      pos_r   <= '0;
      seen_r  <= '0;
      comma_r <= 1'b0;
      err_r   <= alt_pkg::ST_OK;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      comma_r <= comma_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: rtl/alt_out_stage.sv
// Output register stage: holds one result until the receiver takes it.
// Depends on alt_pkg for the result record.
`timescale 1ns / 1ps

module alt_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             res_valid,
  input  alt_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output alt_pkg::result_t out_res
);

  logic             valid_r;
  logic             valid_nxt;
  alt_pkg::result_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/assembly_line_tokenizer.sv
// Top level of the assembly line tokenizer: stream ports, register port, stages.
// Depends on alt_pkg, alt_in_stage, alt_core and alt_out_stage.
`timescale 1ns / 1ps

// The input stream carries one character of a source line per request, and a
// zero character ends the line. The output stream carries one request for each
// name or operand start and one final request per line with its status, marked
// by out_tlast. The number of operands to expect is written through the
// register port at byte address 0 while no line is in flight.
// A character passes an input register and then one state machine step into
// the output register; the step waits while the output register holds a
// result that the receiver is not taking.
// One character is taken in every cycle while the receiver keeps up; the
// single-cycle state machine transition is what sets that rate.
// Reset clears the line state and sets the expected operand count to zero;
// there is no clearing pass, so the block is ready in the first cycle after.
// When the receiver stalls, the held result stays on the output and at most
// one more character is taken into the input register; in_tready then stays
// low until the result is taken.

module assembly_line_tokenizer #(
  parameter int MAX_LINE     = 1024,
  parameter int MAX_OPERANDS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,    // ch[7:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,   // operand_index[4:0], position[14:5],
                                                 // status[18:15], zero fill[23:19]
  output logic [1:0]                out_tuser,   // kind[1:0]
  output logic                      out_tlast,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [alt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  logic             exp_we;
  logic [4:0]       exp_ops_r;
  logic [4:0]       exp_ops_nxt;
  logic             reg_hit;
  logic             q_valid;
  logic [7:0]       q_ch;
  logic             out_free;
  logic             step;
  logic             res_valid;
  alt_pkg::result_t res;
  alt_pkg::result_t out_res;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[alt_pkg::CFG_AW-1:2] == alt_pkg::REG_EXPECTED_OPS);
  assign exp_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit;
  assign exp_ops_nxt = exp_we ? cfg_pwdata[4:0] : exp_ops_r;
  assign cfg_prdata = reg_hit ? {27'd0, exp_ops_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ops_r <= 5'd0;
    end else begin
      exp_ops_r <= exp_ops_nxt;
    end
  end

  assign step = q_valid && out_free;

  alt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_ch    (in_tdata),
    .take     (step),
    .q_valid  (q_valid),
    .q_ch     (q_ch)
  );

  alt_core #(
    .MAX_LINE     (MAX_LINE),
    .MAX_OPERANDS (MAX_OPERANDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ch        (q_ch),
    .exp_ops   (exp_ops_r),
    .res_valid (res_valid),
    .res       (res)
  );

  alt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'd0, out_res.status, out_res.position, out_res.operand_index};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.line_end;

endmodule

FILE: rtl/alt_checker.sv
// Port-level checker for the assembly line tokenizer, bound to the top level.
// Depends on alt_pkg for the result kinds and status codes.
`timescale 1ns / 1ps

module alt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  a_last_is_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == alt_pkg::KIND_FINISH)))
    else $error("line end flag does not match the finish kind");

  a_token_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != alt_pkg::KIND_FINISH) |-> (out_tdata[18:15] == alt_pkg::ST_OK))
    else $error("token start carries a nonzero status");

  a_name_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == alt_pkg::KIND_NAME) |-> (out_tdata[4:0] == 5'd0))
    else $error("name start carries a nonzero operand index");

endmodule

bind assembly_line_tokenizer alt_checker u_alt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: bench/assembly_line_tokenizer_tb.sv
// Self-checking testbench for the assembly line tokenizer.
// Depends on alt_pkg and assembly_line_tokenizer, which in turn needs alt_in_stage, alt_core and alt_out_stage.
`timescale 1ns / 1ps

module assembly_line_tokenizer_tb;

  localparam logic [9:0] LAST_POS    = 10'd1023;
  localparam int         MAX_OPS     = 20;
  localparam int         CYCLE_LIMIT = 300000;

  typedef enum logic [3:0] {
    L_LEAD, L_NAME, L_NAME_QUOTED, L_AFTER_NAME, L_OPND, L_OPND_QUOTED,
    L_GAP, L_GAP_COMMA, L_TRAIL, L_DRAIN
  } lex_phase_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [alt_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Model of the line state, advanced once per accepted character.
  lex_phase_t  lex = L_LEAD;
  logic [9:0]  char_at = '0;
  logic [4:0]  n_read = '0;
  logic        blank_gap_ok = 1'b0;
  logic [3:0]  err_code = alt_pkg::ST_OK;
  logic [4:0]  want_ops = '0;

  logic [7:0]        chars_pending[$];
  logic [7:0]        line_buf[$];
  alt_pkg::result_t  tokens_due[$];
  logic        in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          backpressure_req = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  assembly_line_tokenizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit blank_char(input logic [7:0] c);
    return c == alt_pkg::CH_SPACE || c == alt_pkg::CH_TAB;
  endfunction

  function automatic bit word_body(input logic [7:0] c);
    logic [7:0] up;
    up = c & 8'hDF;
    if (c == alt_pkg::CH_UNDERSCORE) return 1'b1;
    if (c >= 8'h30 && c <= 8'h39) return 1'b1;
    return up >= 8'h41 && up <= 8'h5A && c != up + 8'h80;
  endfunction

  function automatic bit token_opener(input logic [7:0] c);
    return word_body(c) || c == alt_pkg::CH_DOLLAR || c == alt_pkg::CH_QUOTE;
  endfunction

  function automatic void flag_error(input logic [3:0] code);
    if (err_code == alt_pkg::ST_OK) err_code = code;
    lex = L_DRAIN;
  endfunction

  function automatic bit open_operand(input logic [7:0] c, output alt_pkg::result_t r);
    r = '0;
    if (n_read >= want_ops || n_read >= MAX_OPS) begin
      flag_error(alt_pkg::ST_COUNT);
      return 1'b0;
    end
    r.kind = alt_pkg::KIND_OPERAND;
    r.operand_index = n_read;
    r.position = char_at;
    n_read = n_read + 5'd1;
    lex = (c == alt_pkg::CH_QUOTE) ? L_OPND_QUOTED : L_OPND;
    return 1'b1;
  endfunction

  function automatic bit tokenize_char(input logic [7:0] c, output alt_pkg::result_t r);
    bit made;
    made = 1'b0;
    r = '0;
    if (c == alt_pkg::CH_NUL) begin
      r.kind = alt_pkg::KIND_FINISH;
      r.operand_index = n_read;
      r.position = char_at;
      r.line_end = 1'b1;
      if (err_code != alt_pkg::ST_OK) r.status = err_code;
      else begin
        case (lex)
          L_LEAD: r.status = alt_pkg::ST_EMPTY;
          L_NAME_QUOTED, L_OPND_QUOTED: r.status = alt_pkg::ST_OPEN_STR;
          L_GAP, L_GAP_COMMA: r.status = alt_pkg::ST_EARLY_END;
          default: r.status = (n_read < want_ops) ? alt_pkg::ST_EARLY_END : alt_pkg::ST_OK;
        endcase
      end
      lex = L_LEAD;
      char_at = '0;
      n_read = '0;
      blank_gap_ok = 1'b0;
      err_code = alt_pkg::ST_OK;
      return 1'b1;
    end
    if (err_code == alt_pkg::ST_OK && char_at >= LAST_POS) flag_error(alt_pkg::ST_TOO_LONG);
    else if (err_code == alt_pkg::ST_OK) begin
      case (lex)
        L_LEAD: begin
          if (!blank_char(c)) begin
            if (!token_opener(c)) flag_error(alt_pkg::ST_BAD_START);
            else begin
              r.kind = alt_pkg::KIND_NAME;
              r.position = char_at;
              made = 1'b1;
              lex = (c == alt_pkg::CH_QUOTE) ? L_NAME_QUOTED : L_NAME;
            end
          end
        end
        L_NAME: begin
          if (blank_char(c)) lex = L_AFTER_NAME;
          else if (!word_body(c)) flag_error(alt_pkg::ST_BAD_CHAR);
        end
        L_NAME_QUOTED: if (c == alt_pkg::CH_QUOTE) lex = L_NAME;
        L_AFTER_NAME: begin
          if (!blank_char(c)) begin
            if (!token_opener(c)) flag_error(alt_pkg::ST_BAD_START);
            else made = open_operand(c, r);
          end
        end
        L_OPND: begin
          if (blank_char(c) || c == alt_pkg::CH_COMMA) begin
            if (n_read >= want_ops) lex = L_TRAIL;
            else if (c == alt_pkg::CH_COMMA) lex = L_GAP_COMMA;
            else begin
              lex = L_GAP;
              blank_gap_ok = (n_read == 5'd1);
            end
          end else if (!word_body(c)) flag_error(alt_pkg::ST_BAD_CHAR);
        end
        L_OPND_QUOTED: if (c == alt_pkg::CH_QUOTE) lex = L_OPND;
        L_GAP: begin
          if (c == alt_pkg::CH_COMMA) lex = L_GAP_COMMA;
          else if (!blank_char(c)) begin
            if (!token_opener(c)) flag_error(alt_pkg::ST_BAD_CHAR);
            else if (!blank_gap_ok) flag_error(alt_pkg::ST_NO_COMMA);
            else made = open_operand(c, r);
          end
        end
        L_GAP_COMMA: begin
          if (!blank_char(c)) begin
            if (!token_opener(c)) flag_error(alt_pkg::ST_BAD_START);
            else made = open_operand(c, r);
          end
        end
        L_TRAIL: if (!blank_char(c)) flag_error(alt_pkg::ST_TRAILING);
        default: lex = L_DRAIN;
      endcase
    end
    if (char_at < LAST_POS) char_at = char_at + 10'd1;
    return made;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    alt_pkg::result_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      if (tokenize_char(in_tdata, want)) tokens_due.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected result: kind %0d, position %0d", out_tuser, out_tdata[14:5]);
        mismatch_count++;
      end else begin
        want = tokens_due.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("operand_index", want.operand_index, out_tdata[4:0]);
        check_field("position", want.position, out_tdata[14:5]);
        check_field("status", want.status, out_tdata[18:15]);
        check_field("line_end", want.line_end, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= chars_pending.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    int hold_left;
    int holds_served;
    if (backpressure_req != holds_served) begin
      holds_served = backpressure_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    while (chars_pending.size() != 0 || in_tvalid || tokens_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_expected_ops(input logic [4:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {alt_pkg::REG_EXPECTED_OPS, 2'b00};
    cfg_pwdata <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== 32'(val)) begin
      $error("expected_operands readback: expected %0d, got %0d", val, cfg_prdata);
      mismatch_count++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    want_ops = val;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) chars_pending.push_back(s[i]);
    chars_pending.push_back(alt_pkg::CH_NUL);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(62);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 36) return 8'h41 + 8'(r - 10);
    if (r < 62) return 8'h61 + 8'(r - 36);
    return alt_pkg::CH_UNDERSCORE;
  endfunction

  task automatic add_blanks(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) begin
      line_buf.push_back($urandom_range(1) ? alt_pkg::CH_SPACE : alt_pkg::CH_TAB);
    end
  endtask

  task automatic add_token();
    int shape;
    logic [7:0] c;
    shape = $urandom_range(9);
    if (shape == 0) begin
      line_buf.push_back(alt_pkg::CH_QUOTE);
      repeat ($urandom_range(4)) begin
        c = 8'($urandom_range(255, 1));
        line_buf.push_back((c == alt_pkg::CH_QUOTE) ? alt_pkg::CH_SPACE : c);
      end
      line_buf.push_back(alt_pkg::CH_QUOTE);
    end else if (shape == 1) begin
      line_buf.push_back(alt_pkg::CH_DOLLAR);
    end else begin
      line_buf.push_back(word_char());
    end
    repeat ($urandom_range(4)) line_buf.push_back(word_char());
  endtask

  // Mostly well-formed lines with random content; some carry one stray
  // character, some are pure noise.
  task automatic queue_random_line();
    int shape;
    int n_ops;
    line_buf.delete();
    shape = $urandom_range(99);
    if (shape < 10) begin
      repeat ($urandom_range(12, 1)) line_buf.push_back(8'($urandom_range(255, 1)));
    end else begin
      n_ops = want_ops;
      if ($urandom_range(99) < 15) begin
        n_ops = ($urandom_range(1) && n_ops > 0) ? n_ops - 1 : n_ops + 1;
      end
      add_blanks(0, 2);
      add_token();
      for (int i = 0; i < n_ops; i++) begin
        if (i == 0 || (i == 1 && $urandom_range(1))) begin
          add_blanks(1, 2);
        end else begin
          add_blanks(0, 1);
          line_buf.push_back(alt_pkg::CH_COMMA);
          add_blanks(0, 1);
        end
        add_token();
      end
      if (n_ops > 0 && $urandom_range(3) == 0) line_buf.push_back(alt_pkg::CH_COMMA);
      add_blanks(0, 2);
      if (shape < 30) line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255, 1));
    end
    foreach (line_buf[k]) chars_pending.push_back(line_buf[k]);
    chars_pending.push_back(alt_pkg::CH_NUL);
  endtask

  initial begin : stimulus
    int plan [8] = '{2, 0, 1, 3, 20, 5, 2, 0};
    int phase_chars;
    string s;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_text("nop");
    push_text("nop x");
    push_text("");
    push_text(" \t ");
    wait_drained();
    write_expected_ops(5'd2);
    push_text("mov a, b");
    push_text("\tmov\ta b");
    push_text("$mv _a,\"s, t\"x");
    push_text(",x");
    push_text("mov a,,b");
    push_text("mo;v a,b");
    push_text("mov a;,b");
    push_text("mov \"abc");
    push_text("\"ab");
    push_text("mov a");
    push_text("mov a,");
    push_text("mov a, b x");
    push_text("mov a, b,");
    push_text("mov a, b,,");
    wait_drained();
    write_expected_ops(5'd3);
    push_text("op a b c");
    push_text("op a b, c");
    push_text("op a,b ,c");
    wait_drained();
    write_expected_ops(5'd20);
    s = "x o0";
    for (int i = 1; i <= MAX_OPS; i++) begin
      if (i == MAX_OPS) push_text(s);
      s = {s, $sformatf(",o%0d", i)};
    end
    push_text(s);

    for (int k = 0; k < 8; k++) begin
      wait_drained();
      write_expected_ops(5'(plan[k]));
      send_idle_pct = (k % 4 == 1) ? 74 : (k % 4 == 3) ? 19 : 0;
      stall_pct = (k % 4 == 2) ? 74 : (k % 4 == 3) ? 19 : 0;
      phase_chars = chars_pending.size();
      while (chars_pending.size() - phase_chars < 65) queue_random_line();
      if (k == 0) backpressure_req++;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && tokens_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
